### src/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bffa_pkg;

	// Field widths of the request and result words.
	localparam int FUNC_W  = 1;
	localparam int BYTES_W = 13;
	localparam int OFF_W   = 12;

	// Request function codes.
	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

	// The bitmap is held as words of eight unit bits.
	localparam int WORD_BITS = 8;
	localparam int BIT_W     = 3;

	// Numerator width of the divide-by-unit-size stage.
	localparam int DIV_N = 14;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_SCAN,
		ST_MARK_SET,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_DONE
	} bffa_state_t;

	// What the pending result is loaded with.
	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_ALLOC,
		PEND_FREE_OK,
		PEND_ERR
	} bffa_pend_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       mul;
		logic       prep;
		logic       scan;
		logic       mark_set;
		logic       mark_wr;
		logic       free_wr;
		logic       clr;
		logic       out_load;
		bffa_pend_t pend;
	} bffa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic func_free;
		logic free_bad;
		logic mark_none;
		logic found;
		logic scan_end;
		logic mark_last;
		logic free_stop;
		logic free_err;
		logic addr_last;
	} bffa_sts_t;

endpackage

### src/bffa_ctrl.sv
// Controller state machine of the bitmap first-fit allocator.
// Depends on bffa_pkg; drives the datapath bffa_dp through command and status structs.
module bffa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bffa_pkg::bffa_sts_t sts,
	output bffa_pkg::bffa_cmd_t cmd
);
	import bffa_pkg::*;

	bffa_state_t state_q;
	bffa_state_t state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// State register and the output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.addr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				if (!sts.func_free) begin
					state_d = ST_SCAN;
				end else if (sts.free_bad) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FREE_RD;
				end
			end
			ST_SCAN: begin
				if (sts.found) begin
					state_d = ST_MARK_SET;
				end else if (sts.scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_MARK_SET: begin
				state_d = sts.mark_none ? ST_DONE : ST_MARK_RD;
			end
			ST_MARK_RD: begin
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				state_d = sts.mark_last ? ST_DONE : ST_MARK_RD;
			end
			ST_FREE_RD: begin
				state_d = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				state_d = sts.free_stop ? ST_DONE : ST_FREE_RD;
			end
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd      = '0;
		cmd.pend = PEND_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (sts.func_free && sts.free_bad) cmd.pend = PEND_ERR;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (!sts.found && sts.scan_end) cmd.pend = PEND_ERR;
			end
			ST_MARK_SET: begin
				cmd.mark_set = 1'b1;
				cmd.pend     = PEND_ALLOC;
			end
			ST_MARK_WR: begin
				cmd.mark_wr = 1'b1;
			end
			ST_FREE_WR: begin
				cmd.free_wr = 1'b1;
				if (sts.free_stop) cmd.pend = sts.free_err ? PEND_ERR : PEND_FREE_OK;
			end
			ST_DONE: begin
				cmd.out_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// A waiting result word is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result word loaded over one not yet taken");

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in work");

	// A result word appears only after a load.
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("result valid without a load");

endmodule

### src/bffa_dp.sv
// Datapath of the bitmap first-fit allocator: divide stage, bitmap memory,
// scan, mark and free walks, and result registers. Depends on bffa_pkg.
module bffa_dp #(
	parameter int UNIT_COUNT = 256,
	parameter int UNIT_BYTES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [bffa_pkg::FUNC_W-1:0]     func,
	input  logic [bffa_pkg::BYTES_W-1:0]    request_bytes,
	input  logic [bffa_pkg::OFF_W-1:0]      block_offset,
	input  bffa_pkg::bffa_cmd_t             cmd,
	output bffa_pkg::bffa_sts_t             sts,
	output logic [bffa_pkg::OFF_W-1:0]      result_offset,
	output logic                            status
);
	import bffa_pkg::*;

	localparam int WORDS  = (UNIT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int XW     = AW + BIT_W;
	localparam int RUN_W  = $clog2(UNIT_COUNT + 1);
	localparam int MAX_A  = (RUN_W > DIV_N) ? RUN_W : DIV_N;
	localparam int MAX_B  = (MAX_A > XW) ? MAX_A : XW;
	localparam int CMP_W  = MAX_B + 1;
	localparam int PROD_W = 2 * DIV_N + 1;
	localparam int OFF_FW = XW + BYTES_W;

	// Reciprocal of the unit size: floor(x / UNIT_BYTES) = (x * DIV_M) >> DIV_S
	// holds exactly for every x below 2**DIV_N.
	localparam int DIV_L = $clog2(UNIT_BYTES);
	localparam int DIV_S = DIV_N + DIV_L;
	localparam longint unsigned DIV_M_L =
		((64'd1 << DIV_S) + UNIT_BYTES - 1) / UNIT_BYTES;
	localparam logic [DIV_N:0]       DIV_M     = (DIV_N + 1)'(DIV_M_L);
	localparam logic [DIV_N-1:0]     ROUND_C   = DIV_N'(UNIT_BYTES - 1);
	localparam logic [CMP_W-1:0]     UNITS_C   = CMP_W'(UNIT_COUNT);
	localparam logic [AW-1:0]        LAST_WORD = AW'(WORDS - 1);
	localparam logic [OFF_FW-1:0]    UBYTES_C  = OFF_FW'(UNIT_BYTES);

	logic [WORD_BITS-1:0] map_q [WORDS];
	logic [WORD_BITS-1:0] rdata_q;
	logic [AW-1:0]        addr_q;
	logic [AW-1:0]        addr_inc;
	logic [AW-1:0]        widx_q;
	logic                 dv_q;
	logic [FUNC_W-1:0]    func_q;
	logic [DIV_N-1:0]     x_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DIV_N-1:0]     need_q;
	logic [RUN_W-1:0]     run_q;
	logic [XW-1:0]        start_q;
	logic [XW-1:0]        lo_q;
	logic [XW-1:0]        hi_q;
	logic [BIT_W-1:0]     bit_q;
	logic [OFF_W-1:0]     pend_off_q;
	logic                 pend_st_q;
	logic [OFF_W-1:0]     result_offset_q;
	logic                 status_q;

	logic [PROD_W-1:0]    q_full;
	logic [DIV_N-1:0]     q_c;
	logic [CMP_W-1:0]     p_c;
	logic                 free_bad;
	logic [RUN_W-1:0]     run_v;
	logic [XW-1:0]        st_v;
	logic [XW-1:0]        u_v;
	logic                 fnd;
	logic [WORD_BITS-1:0] mmask;
	logic [WORD_BITS-1:0] fclr;
	logic                 going;
	logic                 fstop;
	logic                 ferr;
	logic [XW-1:0]        lo_c;
	logic [OFF_FW-1:0]    off_full;
	logic                 we;
	logic [WORD_BITS-1:0] wdata;

	assign result_offset = result_offset_q;
	assign status        = status_q;
	assign addr_inc      = (addr_q == LAST_WORD) ? addr_q : addr_q + 1'b1;

	// Quotient from the registered product; the free walk starts one unit further.
	assign q_full   = prod_q >> DIV_S;
	assign q_c      = q_full[DIV_N-1:0];
	assign p_c      = CMP_W'(q_c) + CMP_W'(1);
	assign free_bad = (x_q == '0) || (p_c >= UNITS_C);

	// Granted offset and the low end of the run to be marked.
	assign lo_c     = start_q + 1'b1;
	assign off_full = OFF_FW'(start_q) * UBYTES_C + OFF_FW'(1);

	// Scan of one bitmap word for the first run of free units.
	always_comb begin
		run_v = run_q;
		st_v  = start_q;
		fnd   = 1'b0;
		u_v   = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			u_v = {widx_q, BIT_W'(b)};
			if (!fnd) begin
				if ((CMP_W'(u_v) < UNITS_C) && !rdata_q[b]) begin
					if (run_v == '0) st_v = u_v;
					run_v = run_v + 1'b1;
					if (CMP_W'(run_v) == CMP_W'(need_q)) fnd = 1'b1;
				end else begin
					run_v = '0;
				end
			end
		end
	end

	// Units of the current word that lie inside the run to be marked.
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mmask[b] = ({addr_q, BIT_W'(b)} >= lo_q) && ({addr_q, BIT_W'(b)} <= hi_q);
		end
	end

	// Free walk over one word: clear set bits from the start bit on until a
	// clear bit, or the end of the pool, is met.
	always_comb begin
		going = 1'b1;
		fstop = 1'b0;
		ferr  = 1'b0;
		fclr  = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (going && (BIT_W'(b) >= bit_q)) begin
				if (CMP_W'({addr_q, BIT_W'(b)}) >= UNITS_C) begin
					going = 1'b0;
					fstop = 1'b1;
					ferr  = 1'b1;
				end else if (!rdata_q[b]) begin
					going = 1'b0;
					fstop = 1'b1;
				end else begin
					fclr[b] = 1'b1;
				end
			end
		end
		if (going && (addr_q == LAST_WORD)) begin
			fstop = 1'b1;
			ferr  = 1'b1;
		end
	end

	// Status towards the controller.
	always_comb begin
		sts.func_free = (func_q == FUNC_FREE);
		sts.free_bad  = free_bad;
		sts.mark_none = (need_q == DIV_N'(2));
		sts.found     = dv_q && fnd;
		sts.scan_end  = dv_q && (widx_q == LAST_WORD) && !fnd;
		sts.mark_last = (addr_q == hi_q[XW-1:BIT_W]);
		sts.free_stop = fstop;
		sts.free_err  = ferr;
		sts.addr_last = (addr_q == LAST_WORD);
	end

	// Bitmap write port.
	always_comb begin
		we    = cmd.clr || cmd.mark_wr || cmd.free_wr;
		wdata = '0;
		if (cmd.mark_wr) begin
			wdata = rdata_q | mmask;
		end else if (cmd.free_wr) begin
			wdata = rdata_q & ~fclr;
		end
	end

	// Bitmap memory: one word read each cycle, and one written when a write is commanded.
	always_ff @(posedge clk) begin
		if (we) map_q[addr_q] <= wdata;
		rdata_q <= map_q[addr_q];
	end

	// Word address and read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			dv_q   <= 1'b0;
		end else begin
			dv_q <= cmd.scan;
			if (cmd.clr || cmd.scan || cmd.mark_wr) begin
				addr_q <= addr_inc;
			end else if (cmd.prep) begin
				if (func_q != FUNC_FREE) begin
					addr_q <= '0;
				end else if (!free_bad) begin
					addr_q <= p_c[BIT_W +: AW];
				end
			end else if (cmd.mark_set) begin
				addr_q <= lo_c[XW-1:BIT_W];
			end else if (cmd.free_wr && !fstop) begin
				addr_q <= addr_inc;
			end
		end
	end

	// Request operands, divide stage and walk registers.
	always_ff @(posedge clk) begin
		widx_q <= addr_q;
		if (cmd.capture) begin
			func_q <= func;
			if (func == FUNC_FREE) begin
				x_q <= DIV_N'(block_offset);
			end else begin
				x_q <= DIV_N'(request_bytes) + ROUND_C;
			end
		end
		if (cmd.mul) prod_q <= PROD_W'(x_q) * PROD_W'(DIV_M);
		if (cmd.prep) begin
			need_q <= q_c + DIV_N'(2);
			run_q  <= '0;
			bit_q  <= p_c[BIT_W-1:0];
		end
		if (cmd.scan && dv_q) begin
			run_q   <= run_v;
			start_q <= st_v;
		end
		if (cmd.mark_set) begin
			lo_q <= lo_c;
			hi_q <= XW'(CMP_W'(start_q) + CMP_W'(need_q) - CMP_W'(2));
		end
		if (cmd.free_wr) bit_q <= '0;
	end

	// Pending result and the output word.
	always_ff @(posedge clk) begin
		case (cmd.pend)
			PEND_ALLOC: begin
				pend_off_q <= off_full[OFF_W-1:0];
				pend_st_q  <= 1'b0;
			end
			PEND_FREE_OK: begin
				pend_off_q <= '0;
				pend_st_q  <= 1'b0;
			end
			PEND_ERR: begin
				pend_off_q <= '0;
				pend_st_q  <= 1'b1;
			end
			default: begin
				pend_off_q <= pend_off_q;
				pend_st_q  <= pend_st_q;
			end
		endcase
		if (cmd.out_load) begin
			result_offset_q <= pend_off_q;
			status_q        <= pend_st_q;
		end
	end

	// A marked run always spans at least one unit.
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_wr |-> (lo_q <= hi_q))
		else $error("mark write with an empty unit range");

endmodule

### src/bitmap_first_fit_allocator_top.sv
// Bitmap first-fit allocator over a pool of UNIT_COUNT units of UNIT_BYTES bytes,
// one used bit per unit held eight to a word in a single-port bitmap memory.
// After reset a clearing pass writes ceil(UNIT_COUNT/8) words, one a cycle, with
// in_ready low. An allocate divides and sets up, then scans one bitmap word per
// cycle from unit 0 until a run fits or the bitmap ends, then sets up the marked
// run and reads and writes each of its words, if any, and hands the result over.
// A free divides and sets up the same way, then, for a valid offset, reads and
// writes each word walked, and hands the result over. The memory port, one word
// a cycle, sets the scan pace. One request is in work at a time; a new one is
// taken while the previous result word still waits at the output.
module bitmap_first_fit_allocator_top #(
	parameter int UNIT_COUNT = 256,
	parameter int UNIT_BYTES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bffa_pkg::FUNC_W-1:0]  func,
	input  logic [bffa_pkg::BYTES_W-1:0] request_bytes,
	input  logic [bffa_pkg::OFF_W-1:0]   block_offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bffa_pkg::OFF_W-1:0]   result_offset,
	output logic                         status
);
	import bffa_pkg::*;

	bffa_cmd_t cmd;
	bffa_sts_t sts;

	// Controller: sequences the request through the datapath.
	bffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: bitmap and arithmetic.
	bffa_dp #(
		.UNIT_COUNT (UNIT_COUNT),
		.UNIT_BYTES (UNIT_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.request_bytes (request_bytes),
		.block_offset  (block_offset),
		.cmd           (cmd),
		.sts           (sts),
		.result_offset (result_offset),
		.status        (status)
	);

endmodule

### tb/bitmap_first_fit_allocator_top_tb.sv
// Testbench for the bitmap first-fit allocator: directed table, then random words.
// Results are checked against typed rows or a bitmap predictor; uses bffa_pkg.
`timescale 1ns / 100ps

module bitmap_first_fit_allocator_top_tb;

	import bffa_pkg::*;

	localparam int UNIT_COUNT     = 256;
	localparam int UNIT_BYTES     = 16;
	localparam int DIRECTED_ROWS  = 22;
	localparam int RANDOM_WORDS   = 450;
	localparam int QUIET_LIMIT    = 3000;
	localparam int HOLD_CYCLES    = 250;
	localparam int HOLD_AT_RESULT = 120;
	localparam int TAIL_CYCLES    = 60;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic             status;
	} pool_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [BYTES_W-1:0] bytes;
		logic [OFF_W-1:0]   offs;
		logic               typed;
		pool_result_t       want;
	} stim_row_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [FUNC_W-1:0]    func          = FUNC_ALLOC;
	logic [BYTES_W-1:0]   request_bytes = '0;
	logic [OFF_W-1:0]     block_offset  = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [OFF_W-1:0]     result_offset;
	logic                 status;

	// Predictor state and the words still owed by the block.
	logic [UNIT_COUNT-1:0] pool_used = '0;
	pool_result_t          expected_words[$];
	logic [OFF_W-1:0]      live_offsets[$];
	int                    mismatches   = 0;
	int                    results_seen = 0;
	int                    quiet_cycles = 0;
	int                    burst_left   = 0;

	bitmap_first_fit_allocator_top #(
		.UNIT_COUNT(UNIT_COUNT),
		.UNIT_BYTES(UNIT_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.request_bytes(request_bytes),
		.block_offset(block_offset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_offset(result_offset),
		.status(status)
	);

	always #6 clk = ~clk;

	// Applies one request to the predicted bitmap and returns the result word.
	function automatic pool_result_t predict_pool_op(logic [FUNC_W-1:0] f,
			logic [BYTES_W-1:0] bytes, logic [OFF_W-1:0] offs);
		pool_result_t res;
		int need;
		int run;
		int start;
		int p;
		res.offset = '0;
		res.status = STATUS_ERR;
		if (f == FUNC_ALLOC) begin
			need = int'(bytes) / UNIT_BYTES + 2;
			if (int'(bytes) % UNIT_BYTES != 0)
				need++;
			run = 0;
			start = 0;
			for (int u = 0; u < UNIT_COUNT; u++) begin
				if (!pool_used[u]) begin
					if (run == 0)
						start = u;
					run++;
					if (run == need) begin
						// The first and last units of the run stay free as separators.
						for (int k = start + 1; k + 1 < start + need; k++)
							pool_used[k] = 1'b1;
						res.offset = OFF_W'(start * UNIT_BYTES + 1);
						res.status = STATUS_OK;
						return res;
					end
				end else begin
					run = 0;
				end
			end
		end else if (offs != '0) begin
			p = int'(offs) / UNIT_BYTES + 1;
			while (p < UNIT_COUNT && pool_used[p]) begin
				pool_used[p] = 1'b0;
				p++;
			end
			res.status = (p < UNIT_COUNT) ? STATUS_OK : STATUS_ERR;
		end
		return res;
	endfunction

	// Directed table: a result is typed in only where it is plain from the request.
	function automatic stim_row_t directed_row(int idx);
		stim_row_t row;
		row = '0;
		case (idx)
			// Zero-byte allocate straight after reset lands on unit 0.
			0:  row = '{FUNC_ALLOC, 13'd0,    12'd0,    1'b1, '{12'd1, STATUS_OK}};
			// Null free.
			1:  row = '{FUNC_FREE,  13'd0,    12'd0,    1'b1, '{12'd0, STATUS_ERR}};
			// Requests at least as large as the whole pool.
			2:  row = '{FUNC_ALLOC, 13'd4096, 12'd0,    1'b1, '{12'd0, STATUS_ERR}};
			3:  row = '{FUNC_ALLOC, 13'd8191, 12'd0,    1'b1, '{12'd0, STATUS_ERR}};
			// Free that starts beyond the last unit.
			4:  row = '{FUNC_FREE,  13'd0,    12'd4095, 1'b1, '{12'd0, STATUS_ERR}};
			5:  row = '{FUNC_FREE,  13'd0,    12'd4080, 1'b1, '{12'd0, STATUS_ERR}};
			// Fill the pool, then ask for more while it is full.
			6:  row = '{FUNC_ALLOC, 13'd4064, 12'd0,    1'b0, '0};
			7:  row = '{FUNC_ALLOC, 13'd1,    12'd0,    1'b0, '0};
			8:  row = '{FUNC_ALLOC, 13'd0,    12'd0,    1'b0, '0};
			// Free with an offset that allocate never returned.
			9:  row = '{FUNC_FREE,  13'd0,    12'd3,    1'b0, '0};
			10: row = '{FUNC_FREE,  13'd0,    12'd16,   1'b0, '0};
			11: row = '{FUNC_ALLOC, 13'd15,   12'd0,    1'b0, '0};
			12: row = '{FUNC_ALLOC, 13'd16,   12'd0,    1'b0, '0};
			13: row = '{FUNC_ALLOC, 13'd17,   12'd0,    1'b0, '0};
			14: row = '{FUNC_ALLOC, 13'd4095, 12'd0,    1'b0, '0};
			15: row = '{FUNC_FREE,  13'd0,    12'd1,    1'b0, '0};
			16: row = '{FUNC_FREE,  13'd0,    12'hAAA,  1'b0, '0};
			17: row = '{FUNC_FREE,  13'd0,    12'h555,  1'b0, '0};
			18: row = '{FUNC_ALLOC, 13'h1555, 12'd0,    1'b0, '0};
			19: row = '{FUNC_ALLOC, 13'hAAA,  12'd0,    1'b0, '0};
			// Free that starts on the last unit.
			20: row = '{FUNC_FREE,  13'd0,    12'd4079, 1'b0, '0};
			21: row = '{FUNC_ALLOC, 13'd32,   12'd0,    1'b0, '0};
			default: row = '0;
		endcase
		return row;
	endfunction

	// Offers one request word, waits for it to be taken, and records what it owes.
	task automatic offer_word(input logic [FUNC_W-1:0] f, input logic [BYTES_W-1:0] b,
			input logic [OFF_W-1:0] o, input logic typed, input pool_result_t want);
		pool_result_t pred;
		int gap;
		in_valid      <= 1'b1;
		func          <= f;
		request_bytes <= b;
		block_offset  <= o;
		do
			@(posedge clk);
		while (!in_ready);
		pred = predict_pool_op(f, b, o);
		expected_words.push_back(typed ? want : pred);
		if (f == FUNC_ALLOC && pred.status == STATUS_OK)
			live_offsets.push_back(pred.offset);
		// The sender works in bursts with random gaps between them.
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Stops offering and waits until every owed word has come back. With nothing
	// owed the sender is already idle, so valid is left alone.
	task automatic drain_results();
		if (expected_words.size() != 0)
			in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus: reset, directed table, then random requests.
	initial begin
		stim_row_t row;
		int pick;
		int idx;
		logic [BYTES_W-1:0] bytes;
		logic [OFF_W-1:0] offs;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 24);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_row(i);
			offer_word(row.func, row.bytes, row.offs, row.typed, row.want);
		end
		drain_results();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// Once midway the sender waits for the block to empty completely.
			if (n == RANDOM_WORDS / 2)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 40 && live_offsets.size() != 0) begin
				idx = $urandom_range(0, live_offsets.size() - 1);
				offs = live_offsets[idx];
				live_offsets.delete(idx);
				offer_word(FUNC_FREE, BYTES_W'($urandom), offs, 1'b0, '0);
			end else if (pick < 48) begin
				// Stray frees: any offset, the null one included.
				offs = ($urandom_range(0, 7) == 0) ? '0 : OFF_W'($urandom_range(1, 4095));
				offer_word(FUNC_FREE, BYTES_W'($urandom), offs, 1'b0, '0);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					bytes = BYTES_W'($urandom_range(0, 128));
				else if (pick < 93)
					bytes = BYTES_W'($urandom_range(0, 1024));
				else if (pick < 98)
					bytes = BYTES_W'($urandom_range(0, 4096));
				else
					bytes = BYTES_W'($urandom_range(0, 8191));
				offer_word(FUNC_ALLOC, bytes, OFF_W'($urandom), 1'b0, '0);
			end
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_words.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Receiver: changing stall patterns, plus one long hold-off to back up the block.
	always @(posedge clk or negedge arst_n) begin : receiver
		int hold_left;
		int mode;
		int mode_cycles;
		bit hold_done;
		if (!arst_n) begin
			out_ready   <= 1'b0;
			hold_left   = 0;
			mode        = 0;
			mode_cycles = 0;
			hold_done   = 1'b0;
		end else begin
			if (mode_cycles == 0) begin
				mode        = $urandom_range(0, 3);
				mode_cycles = $urandom_range(20, 80);
			end else begin
				mode_cycles--;
			end
			if (hold_left == 0 && !hold_done && results_seen >= HOLD_AT_RESULT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 0);
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= (mode_cycles % 4 != 0);
				endcase
			end
		end
	end

	// Each accepted result word is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		pool_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_words.size() == 0) begin
				$error("unexpected result word: result_offset=%0d status=%0d",
					result_offset, status);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (result_offset !== want.offset) begin
					$error("result_offset: expected %0d, actual %0d", want.offset,
						result_offset);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

### sim.f
src/bffa_pkg.sv
src/bffa_ctrl.sv
src/bffa_dp.sv
src/bitmap_first_fit_allocator_top.sv
tb/bitmap_first_fit_allocator_top_tb.sv
